// ===== src/dsqrt_pkg.sv =====
// Shared types and constants for the double-precision square root pipeline.
package dsqrt_pkg;

  localparam logic [63:0] IndefNan  = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QuietBit  = 64'h0008_0000_0000_0000;
  localparam int          NumSteps  = 64;
  localparam logic [10:0] ExpAll    = 11'h7FF;
  localparam logic [10:0] RoundHalf = 11'h400;

  // Decoded operand after the first stage.
  typedef struct packed {
    logic        special;
    logic [63:0] spec_res;
    logic        err;
    logic        variant;
    logic [52:0] mant;
    logic [5:0]  lz;
    logic [11:0] e_adj;
  } dec_t;

  // Payload that flows through the root recurrence.
  typedef struct packed {
    logic        special;
    logic [63:0] spec_res;
    logic        err;
    logic        variant;
    logic [10:0] be;
    logic [66:0] rem;
    logic [63:0] root;
    logic [63:0] rad;
  } item_t;

  // Payload after the first rounding stage.
  typedef struct packed {
    logic        special;
    logic [63:0] spec_res;
    logic        err;
    logic        sticky;
    logic [10:0] be;
    logic [63:0] r;
  } rnd_t;

endpackage

// ===== src/double_sqrt_x87_rounding_unit.sv =====
// Stages in order: decode, 64 root stages (one root bit each), first rounding, output.
// Throughput: one transaction per cycle while the output register is not stalled.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset clears all valid bits and sets the rounding variant to 0 (double rounding).
// No clearing pass or warm-up is needed after reset.
module double_sqrt_x87_rounding_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] operand_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [63:0] result_bits, [64] domain_error, zero fill
);

  localparam int N = dsqrt_pkg::NumSteps;

  logic             variant_q;
  logic             en;
  dsqrt_pkg::dec_t  dec_d, dec_q;
  logic             dec_valid_q;
  dsqrt_pkg::item_t init_item;
  dsqrt_pkg::item_t chain [N+1];
  logic             chain_valid [N+1];
  dsqrt_pkg::rnd_t  rnd_d, rnd_q;
  logic             rnd_valid_q;
  logic [63:0]      res_d, res_q;
  logic             err_q;
  logic             out_valid_q;

  // Input decode fields.
  logic        sgn;
  logic [10:0] expf;
  logic [51:0] frac;
  logic [5:0]  lz;

  // Pipeline advances when the output register is free or being drained.
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 1'b0;
    end else if (cfg_we_i) begin
      variant_q <= cfg_wdata_i;
    end
  end

  // Classify the operand and find the leading one of a subnormal fraction.
  always_comb begin
    sgn  = s_axis_tdata[63];
    expf = s_axis_tdata[62:52];
    frac = s_axis_tdata[51:0];
    lz   = '0;
    for (int i = 0; i < 52; i++) begin
      if (frac[i]) begin
        lz = 6'(52 - i);
      end
    end
    dec_d          = '0;
    dec_d.variant  = variant_q;
    dec_d.spec_res = s_axis_tdata;
    if (expf == dsqrt_pkg::ExpAll) begin
      dec_d.special = 1'b1;
      if (frac != '0) begin
        dec_d.spec_res = s_axis_tdata | dsqrt_pkg::QuietBit;
      end else if (sgn) begin
        dec_d.spec_res = dsqrt_pkg::IndefNan;
        dec_d.err      = 1'b1;
      end
    end else if (sgn) begin
      dec_d.special = 1'b1;
      if (expf != '0 || frac != '0) begin
        dec_d.spec_res = dsqrt_pkg::IndefNan;
        dec_d.err      = 1'b1;
      end
    end else if (expf == '0 && frac == '0) begin
      dec_d.special = 1'b1;
    end
    if (expf == '0) begin
      dec_d.mant  = {1'b0, frac};
      dec_d.lz    = lz;
      dec_d.e_adj = 12'd1024 - {6'd0, lz};
    end else begin
      dec_d.mant  = {1'b1, frac};
      dec_d.lz    = '0;
      dec_d.e_adj = {1'b0, expf} + 12'd1023;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_valid_q <= 1'b0;
    end else if (en) begin
      dec_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dec_q <= dec_d;
    end
  end

  // Normalize the significand and align it so the exponent becomes even.
  logic [52:0] mant_n;
  always_comb begin
    mant_n             = dec_q.mant << dec_q.lz;
    init_item          = '0;
    init_item.special  = dec_q.special;
    init_item.spec_res = dec_q.spec_res;
    init_item.err      = dec_q.err;
    init_item.variant  = dec_q.variant;
    init_item.be       = dec_q.e_adj[11:1];
    init_item.rad      = dec_q.e_adj[0] ? {mant_n, 11'd0} : {1'b0, mant_n, 10'd0};
  end

  assign chain[0]       = init_item;
  assign chain_valid[0] = dec_valid_q;

  // Root recurrence, one bit per stage.
  for (genvar g = 0; g < N; g++) begin : g_step
    dsqrt_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[g]),
      .item_i  (chain[g]),
      .valid_o (chain_valid[g+1]),
      .item_o  (chain[g+1])
    );
  end

  // First rounding: extended-precision rounding, or a sticky bit for single rounding.
  logic        above;
  logic [64:0] r_inc;
  always_comb begin
    above          = chain[N].rem > {3'd0, chain[N].root};
    rnd_d.special  = chain[N].special;
    rnd_d.spec_res = chain[N].spec_res;
    rnd_d.err      = chain[N].err;
    rnd_d.sticky   = chain[N].variant && (chain[N].rem != '0);
    rnd_d.be       = chain[N].be;
    rnd_d.r        = chain[N].root;
    r_inc          = {1'b0, chain[N].root} + {64'd0, above};
    if (!chain[N].variant) begin
      if (r_inc[64]) begin
        rnd_d.r  = 64'h8000_0000_0000_0000;
        rnd_d.be = chain[N].be + 11'd1;
      end else begin
        rnd_d.r = r_inc[63:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
    end else if (en) begin
      rnd_valid_q <= chain_valid[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rnd_q <= rnd_d;
    end
  end

  // Final rounding to 53 bits, nearest even, and result assembly.
  logic [10:0] low;
  logic        up;
  logic [53:0] sig;
  logic [10:0] be_f;
  always_comb begin
    low  = rnd_q.r[10:0];
    up   = (low > dsqrt_pkg::RoundHalf) ||
           ((low == dsqrt_pkg::RoundHalf) && (rnd_q.r[11] || rnd_q.sticky));
    sig  = {1'b0, rnd_q.r[63:11]} + {53'd0, up};
    be_f = rnd_q.be;
    if (sig[53]) begin
      be_f = rnd_q.be + 11'd1;
    end
    if (rnd_q.special) begin
      res_d = rnd_q.spec_res;
    end else begin
      res_d = {1'b0, be_f, (sig[53] ? 52'd0 : sig[51:0])};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= rnd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      err_q <= rnd_q.err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, err_q, res_q};

endmodule

// ===== src/dsqrt_step.sv =====
// One pipeline stage of the restoring square root recurrence (one root bit).
module dsqrt_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  dsqrt_pkg::item_t item_i,
  output logic            valid_o,
  output dsqrt_pkg::item_t item_o
);

  logic [66:0]      rem_sh;
  logic [66:0]      trial;
  logic             take;
  dsqrt_pkg::item_t item_d;
  dsqrt_pkg::item_t item_q;
  logic             valid_q;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh      = {item_i.rem[64:0], item_i.rad[63:62]};
    trial       = {1'b0, item_i.root, 2'b01};
    take        = (rem_sh >= trial);
    item_d      = item_i;
    item_d.rad  = {item_i.rad[61:0], 2'b00};
    item_d.rem  = take ? (rem_sh - trial) : rem_sh;
    item_d.root = {item_i.root[62:0], take};
  end

  // Valid bit is control state; the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/dsqrt_checker.sv =====
// Port-level assertions for the square root unit, bound to the top level.
module dsqrt_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // A result that is stalled keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A domain error always carries the indefinite NaN.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[63:0] == dsqrt_pkg::IndefNan)
    else $error("domain error without indefinite NaN");

  // The fill bits above the flag stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:65] == '0)
    else $error("fill bits not zero");

  // With the output register empty the input side is always open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output is empty");

endmodule

bind double_sqrt_x87_rounding_unit dsqrt_props u_dsqrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/dsqrt_checker.sv =====
// Checker for the square root unit: predicts each result and compares it on the master side.
module dsqrt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] operand_bits
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,   // [63:0] result_bits, [64] domain_error, zero fill
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        domain_error;
    logic [63:0] result_bits;
  } root_result_t;

  root_result_t expected_roots[$];
  logic         variant_q;

  // Root of a positive finite nonzero operand, rounded per the selected variant.
  function automatic logic [63:0] finite_root(logic [63:0] bits, logic single_round);
    logic [63:0]  m;
    logic [63:0]  xh;
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] radicand;
    logic [127:0] rem;
    logic [64:0]  rr;
    logic [10:0]  low;
    logic [53:0]  sig;
    logic         above;
    logic         inexact;
    logic         up;
    int           eb;
    int           s;
    int           q;
    int           be;
    eb = int'(bits[62:52]);
    if (eb == 0) begin
      m = {12'd0, bits[51:0]};
      eb = 1;
      while (m[52] == 1'b0) begin
        m = m << 1;
        eb--;
      end
    end else begin
      m = {11'd0, 1'b1, bits[51:0]};
    end
    // Shift so that the remaining exponent is even.
    s = ((eb + 1000) % 2 != 0) ? 74 : 75;
    xh = m << (s - 64);
    radicand = {xh, 64'd0};
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= radicand) r = t;
    end
    rem = radicand - {64'd0, r} * {64'd0, r};
    inexact = rem != 0;
    above = rem > {64'd0, r};
    q = (eb - 1075 - s) / 2;
    be = q + 11 + 1075;
    if (!single_round) begin
      // First rounding to the 64-bit extended significand.
      rr = {1'b0, r} + (above ? 65'd1 : 65'd0);
      if (rr[64]) begin
        r = 64'h8000_0000_0000_0000;
        be++;
      end else begin
        r = rr[63:0];
      end
      low = r[10:0];
      up = low > dsqrt_pkg::RoundHalf || (low == dsqrt_pkg::RoundHalf && r[11]);
    end else begin
      low = r[10:0];
      up = low > dsqrt_pkg::RoundHalf ||
           (low == dsqrt_pkg::RoundHalf && (inexact || r[11]));
    end
    sig = {1'b0, r[63:11]} + (up ? 54'd1 : 54'd0);
    if (sig[53]) begin
      sig = sig >> 1;
      be++;
    end
    return {1'b0, be[10:0], sig[51:0]};
  endfunction

  // Full prediction including the special operand classes.
  function automatic root_result_t predict_root(logic [63:0] bits, logic single_round);
    root_result_t res;
    res.domain_error = 1'b0;
    if (bits[62:52] == dsqrt_pkg::ExpAll) begin
      if (bits[51:0] != 0) begin
        res.result_bits = bits | dsqrt_pkg::QuietBit;
      end else if (!bits[63]) begin
        res.result_bits = bits;
      end else begin
        res.result_bits = dsqrt_pkg::IndefNan;
        res.domain_error = 1'b1;
      end
    end else if (bits[63]) begin
      if (bits[62:0] != 0) begin
        res.result_bits = dsqrt_pkg::IndefNan;
        res.domain_error = 1'b1;
      end else begin
        res.result_bits = bits;
      end
    end else if (bits[62:0] == 0) begin
      res.result_bits = bits;
    end else begin
      res.result_bits = finite_root(bits, single_round);
    end
    return res;
  endfunction

  // Track the configuration, queue predictions and compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    root_result_t exp_r;
    int           errs;
    errs = 0;
    if (!rst_ni) begin
      variant_q <= 1'b0;
      expected_roots.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) variant_q <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        expected_roots.push_back(predict_root(s_axis_tdata, variant_q));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_roots.size() == 0) begin
          $error("unexpected result transaction: data %h", m_axis_tdata);
          errs++;
        end else begin
          exp_r = expected_roots.pop_front();
          if (m_axis_tdata[63:0] !== exp_r.result_bits) begin
            $error("result_bits: expected %h, actual %h", exp_r.result_bits,
                   m_axis_tdata[63:0]);
            errs++;
          end
          if (m_axis_tdata[64] !== exp_r.domain_error) begin
            $error("domain_error: expected %b, actual %b", exp_r.domain_error,
                   m_axis_tdata[64]);
            errs++;
          end
          if (m_axis_tdata[71:65] !== 7'd0) begin
            $error("zero fill: expected %h, actual %h", 7'd0, m_axis_tdata[71:65]);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o <= expected_roots.size();
    end
  end

endmodule

// ===== tb/tb_double_sqrt_x87_rounding_unit.sv =====
// Top of the square root testbench: clock, reset, stimulus and verdict.
module tb_double_sqrt_x87_rounding_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  bit          no_idle;
  int          recv_cycle;

  double_sqrt_x87_rounding_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dsqrt_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off so the pipeline backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_cycle <= 0;
    end else begin
      recv_cycle <= recv_cycle + 1;
      if (recv_cycle >= 100 && recv_cycle < 400) m_axis_tready <= 1'b0;
      else m_axis_tready <= no_idle || ($urandom_range(99) >= 17);
    end
  end

  // Offer one operand and wait until the transaction is accepted.
  task automatic send_operand(input logic [63:0] op);
    while (!no_idle && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drain all outstanding results, then let the pipeline settle.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_variant(input logic v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random operand with weight on positive finite values.
  function automatic logic [63:0] random_operand();
    logic [63:0] op;
    int          pick;
    op = {$urandom(), $urandom()};
    pick = $urandom_range(99);
    if (pick < 60) op[63:52] = {1'b0, 11'($urandom_range(2046, 1))};
    else if (pick < 70) op[63:52] = 12'h000;
    else if (pick < 80) op[63] = 1'b1;
    else if (pick < 90) op[62:52] = 11'h7FF;
    return op;
  endfunction

  task automatic directed_operands();
    logic [63:0] ops [21];
    ops = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
            64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
            64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0001,
            64'hFFF5_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
            64'h8000_0000_0000_0001, 64'hBFF0_0000_0000_0000,
            64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000,
            64'h4010_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
            64'h0010_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF,
            64'h3FF0_0000_0000_0001, 64'h5555_5555_5555_5555,
            64'h2AAA_AAAA_AAAA_AAAA};
    foreach (ops[i]) send_operand(ops[i]);
  endtask

  task automatic random_operands(input int count);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3) && (i < count / 2);
      send_operand(random_operand());
    end
    no_idle = 1'b0;
  endtask

  // Main sequence: phases over both rounding variants.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_operands();
    random_operands(250);
    drain_pipeline();
    write_variant(1'b1);
    directed_operands();
    random_operands(250);
    drain_pipeline();
    write_variant(1'b0);
    random_operands(200);
    drain_pipeline();
    write_variant(1'b1);
    random_operands(200);
    drain_pipeline();
    if (fail_count == 0) $display("tb_double_sqrt_x87_rounding_unit: PASS");
    else $display("tb_double_sqrt_x87_rounding_unit: FAIL");
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("tb_double_sqrt_x87_rounding_unit: FAIL");
    $finish;
  end

endmodule

// ===== double_sqrt_x87_rounding_unit.f =====
src/dsqrt_pkg.sv
src/dsqrt_step.sv
src/double_sqrt_x87_rounding_unit.sv
src/dsqrt_checker.sv
tb/dsqrt_checker.sv
tb/tb_double_sqrt_x87_rounding_unit.sv
